@@ rtl/first_fit_block_allocator_core_macros.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FFBA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");
`define FFBA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");
`else
`define FFBA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FFBA_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/ffba_pkg.sv @@
// Types and constants of the first-fit block allocator.
`timescale 1ns / 1ps
package ffba_pkg;
   localparam int ADDR_W = 25;
   localparam int OFS_W  = 24;
   localparam int REQ_W  = 25;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_NOSPACE = 2'd1,
      STAT_FULL    = 2'd2,
      STAT_UNKNOWN = 2'd3
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] e;
   } blk_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_A_CHK,
      ST_A_CMP,
      ST_E_CHK,
      ST_E_WR,
      ST_F_CHK,
      ST_F_CMP,
      ST_D_BEGIN,
      ST_D_RDI,
      ST_D_KEY,
      ST_D_RDJ,
      ST_D_CMP,
      ST_M_HEAD,
      ST_M_CHK,
      ST_M_STEP,
      ST_DONE
   } state_type;
endpackage

@@ rtl/first_fit_block_allocator_core.sv @@
// Top level of the first-fit block allocator with its sequencer and tables.
`timescale 1ns / 1ps
// The allocator manages a pool of POOL_BYTES bytes with a free-block table and an
// allocated-block table, each held in a single-port-write memory with a registered
// read. An allocate transaction takes the first free block that is large enough,
// splitting it from the front or removing it on an exact fit; a free transaction
// looks up the allocated block by start address, removes it in order and appends
// it to the free table. One sequencer drives one compare and subtract unit over
// the table entries, so how long a transaction takes depends on the tables: an
// allocate scans the free entries and, on an exact fit, moves the entries behind
// the taken one; a free scans the allocated entries and moves the entries behind
// the one it removes. When no block fits, the free table is sorted by insertion
// (compares and moves grow quadratically with the free count) and then merged in
// one pass before the scan is repeated. Each transaction ends in a hand-off state
// that passes the result to the output register; it waits there for as long as
// the output register still holds an earlier result that rsp_stall keeps back.
// req_stall stays high from acceptance until the hand-off. After reset the block
// loads the initial free block before it accepts a transaction.
// The output register holds a finished result while the next request is taken.
module first_fit_block_allocator_core #(
   parameter int POOL_BYTES = 16777216,
   parameter int FREE_SLOTS = 64,
   parameter int USED_SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [ffba_pkg::REQ_W-1:0] req_request_bytes,
   input  logic [ffba_pkg::OFS_W-1:0] req_block_start,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [ffba_pkg::OFS_W-1:0] rsp_granted_start
);
   import ffba_pkg::*;
`include "first_fit_block_allocator_core_macros.svh"

   localparam int FCW = $clog2(FREE_SLOTS + 1);
   localparam int UCW = $clog2(USED_SLOTS + 1);
   localparam int CW  = (FCW > UCW) ? FCW : UCW;
   localparam int FAW = $clog2(FREE_SLOTS);
   localparam int UAW = $clog2(USED_SLOTS);
   localparam logic [FCW-1:0] FREE_FULL = FCW'(FREE_SLOTS);
   localparam logic [UCW-1:0] USED_FULL = UCW'(USED_SLOTS);

   // Table memories.
   blk_type free_mem [FREE_SLOTS];
   blk_type used_mem [USED_SLOTS];
   blk_type free_rd_ff;
   blk_type used_rd_ff;
   logic           free_we, used_we;
   logic [FAW-1:0] free_wa, free_ra;
   logic [UAW-1:0] used_wa, used_ra;
   blk_type        free_wd, used_wd;

   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_wa] <= free_wd;
      end
      free_rd_ff <= free_mem[free_ra];
   end

   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      used_rd_ff <= used_mem[used_ra];
   end

   // Control and working registers.
   state_type          state_ff, state_in;
   logic [FCW-1:0]     fc_ff, fc_in;
   logic [UCW-1:0]     uc_ff, uc_in;
   logic               retry_ff, retry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               op_ff, op_in;
   logic [REQ_W-1:0]   reqb_ff, reqb_in;
   logic [OFS_W-1:0]   addr_ff, addr_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      aux_ff, aux_in;
   blk_type            cur_ff, cur_in;
   status_type         res_status_ff, res_status_in;
   logic [OFS_W-1:0]   res_grant_ff, res_grant_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [OFS_W-1:0]   rsp_grant_ff, rsp_grant_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         fc_ff        <= FCW'(1);
         uc_ff        <= '0;
         retry_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fc_ff        <= fc_in;
         uc_ff        <= uc_in;
         retry_ff     <= retry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      reqb_ff       <= reqb_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      aux_ff        <= aux_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_grant_ff  <= res_grant_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
   end

   // The shared compare and subtract unit works on the entry just read.
   logic [CW-1:0]     fc_x, uc_x, idx_p1, aux_p1, aux_m1;
   logic [ADDR_W-1:0] blk_size, split_at;
   logic              size_gt, size_eq;

   always_comb begin
      fc_x     = CW'(fc_ff);
      uc_x     = CW'(uc_ff);
      idx_p1   = idx_ff + CW'(1);
      aux_p1   = aux_ff + CW'(1);
      aux_m1   = aux_ff - CW'(1);
      blk_size = free_rd_ff.e - free_rd_ff.s;
      split_at = free_rd_ff.s + reqb_ff;
      size_gt  = blk_size > reqb_ff;
      size_eq  = blk_size == reqb_ff;
   end

   always_comb begin
      state_in      = state_ff;
      fc_in         = fc_ff;
      uc_in         = uc_ff;
      retry_in      = retry_ff;
      op_in         = op_ff;
      reqb_in       = reqb_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      aux_in        = aux_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_grant_in  = res_grant_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      free_we       = 1'b0;
      free_wa       = '0;
      free_wd       = free_rd_ff;
      free_ra       = idx_ff[FAW-1:0];
      used_we       = 1'b0;
      used_wa       = uc_ff[UAW-1:0];
      used_wd       = used_rd_ff;
      used_ra       = idx_ff[UAW-1:0];

      case (state_ff)
         ST_INIT: begin
            // The pool starts as one free block.
            free_we  = 1'b1;
            free_wa  = '0;
            free_wd  = '{s: '0, e: ADDR_W'(POOL_BYTES)};
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_opcode;
               reqb_in       = req_request_bytes;
               addr_in       = req_block_start;
               idx_in        = '0;
               retry_in      = 1'b0;
               res_grant_in  = '0;
               res_status_in = STAT_OK;
               if (req_opcode == OP_FREE) begin
                  state_in = ST_F_CHK;
               end else if (uc_ff >= USED_FULL) begin
                  res_status_in = STAT_FULL;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_A_CHK;
               end
            end
         end
         ST_A_CHK: begin
            if (idx_ff < fc_x) begin
               state_in = ST_A_CMP;
            end else if (!retry_ff) begin
               state_in = ST_D_BEGIN;
            end else begin
               res_status_in = STAT_NOSPACE;
               state_in      = ST_DONE;
            end
         end
         ST_A_CMP: begin
            if (size_gt || size_eq) begin
               used_we      = 1'b1;
               used_wa      = uc_ff[UAW-1:0];
               uc_in        = uc_ff + UCW'(1);
               res_grant_in = free_rd_ff.s[OFS_W-1:0];
               if (size_gt) begin
                  used_wd  = '{s: free_rd_ff.s, e: split_at};
                  free_we  = 1'b1;
                  free_wa  = idx_ff[FAW-1:0];
                  free_wd  = '{s: split_at, e: free_rd_ff.e};
                  state_in = ST_DONE;
               end else begin
                  used_wd  = free_rd_ff;
                  aux_in   = idx_ff;
                  state_in = ST_E_CHK;
               end
            end else begin
               idx_in   = idx_p1;
               state_in = ST_A_CHK;
            end
         end
         ST_E_CHK: begin
            // Ordered erase at aux: the free table for an allocate, else the used table.
            free_ra = aux_p1[FAW-1:0];
            used_ra = aux_p1[UAW-1:0];
            if (op_ff == OP_ALLOC) begin
               if (aux_p1 < fc_x) begin
                  state_in = ST_E_WR;
               end else begin
                  fc_in    = fc_ff - FCW'(1);
                  state_in = ST_DONE;
               end
            end else begin
               if (aux_p1 < uc_x) begin
                  state_in = ST_E_WR;
               end else begin
                  uc_in    = uc_ff - UCW'(1);
                  state_in = ST_DONE;
               end
            end
         end
         ST_E_WR: begin
            if (op_ff == OP_ALLOC) begin
               free_we = 1'b1;
               free_wa = aux_ff[FAW-1:0];
            end else begin
               used_we = 1'b1;
               used_wa = aux_ff[UAW-1:0];
            end
            aux_in   = aux_p1;
            state_in = ST_E_CHK;
         end
         ST_F_CHK: begin
            if (idx_ff < uc_x) begin
               state_in = ST_F_CMP;
            end else begin
               res_status_in = STAT_UNKNOWN;
               state_in      = ST_DONE;
            end
         end
         ST_F_CMP: begin
            if (used_rd_ff.s == {1'b0, addr_ff}) begin
               if (fc_ff >= FREE_FULL) begin
                  res_status_in = STAT_FULL;
                  state_in      = ST_DONE;
               end else begin
                  free_we  = 1'b1;
                  free_wa  = fc_ff[FAW-1:0];
                  free_wd  = used_rd_ff;
                  fc_in    = fc_ff + FCW'(1);
                  aux_in   = idx_ff;
                  state_in = ST_E_CHK;
               end
            end else begin
               idx_in   = idx_p1;
               state_in = ST_F_CHK;
            end
         end
         ST_D_BEGIN: begin
            retry_in = 1'b1;
            if (fc_ff <= FCW'(1)) begin
               idx_in   = '0;
               state_in = ST_A_CHK;
            end else begin
               idx_in   = CW'(1);
               state_in = ST_D_RDI;
            end
         end
         ST_D_RDI: begin
            // Insertion sort by start, then end.
            if (idx_ff < fc_x) begin
               state_in = ST_D_KEY;
            end else begin
               free_ra  = '0;
               state_in = ST_M_HEAD;
            end
         end
         ST_D_KEY: begin
            cur_in   = free_rd_ff;
            aux_in   = idx_ff;
            state_in = ST_D_RDJ;
         end
         ST_D_RDJ: begin
            free_ra = aux_m1[FAW-1:0];
            if (aux_ff != '0) begin
               state_in = ST_D_CMP;
            end else begin
               free_we  = 1'b1;
               free_wa  = aux_ff[FAW-1:0];
               free_wd  = cur_ff;
               idx_in   = idx_p1;
               state_in = ST_D_RDI;
            end
         end
         ST_D_CMP: begin
            free_we = 1'b1;
            free_wa = aux_ff[FAW-1:0];
            if ((free_rd_ff.s > cur_ff.s) ||
                ((free_rd_ff.s == cur_ff.s) && (free_rd_ff.e > cur_ff.e))) begin
               free_wd  = free_rd_ff;
               aux_in   = aux_m1;
               state_in = ST_D_RDJ;
            end else begin
               free_wd  = cur_ff;
               idx_in   = idx_p1;
               state_in = ST_D_RDI;
            end
         end
         ST_M_HEAD: begin
            // Merge pass: aux is the write slot, idx the read slot.
            cur_in   = free_rd_ff;
            aux_in   = '0;
            idx_in   = CW'(1);
            state_in = ST_M_CHK;
         end
         ST_M_CHK: begin
            if (idx_ff < fc_x) begin
               state_in = ST_M_STEP;
            end else begin
               free_we  = 1'b1;
               free_wa  = aux_ff[FAW-1:0];
               free_wd  = cur_ff;
               fc_in    = aux_p1[FCW-1:0];
               idx_in   = '0;
               state_in = ST_A_CHK;
            end
         end
         ST_M_STEP: begin
            if (cur_ff.e == free_rd_ff.s) begin
               cur_in.e = free_rd_ff.e;
            end else begin
               free_we = 1'b1;
               free_wa = aux_ff[FAW-1:0];
               free_wd = cur_ff;
               aux_in  = aux_p1;
               cur_in  = free_rd_ff;
            end
            idx_in   = idx_p1;
            state_in = ST_M_CHK;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_grant_in  = (res_status_ff == STAT_OK) ? res_grant_ff : '0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_start = rsp_grant_ff;

   `FFBA_ASSERT_IMP(a_free_count_bound, clock, reset, 1'b1, fc_ff <= FREE_FULL)
   `FFBA_ASSERT_IMP(a_used_count_bound, clock, reset, 1'b1, uc_ff <= USED_FULL)
   `FFBA_ASSERT_NXT(a_accept_leaves_idle, clock, reset, req_valid && !req_stall,
                    state_ff != ST_IDLE)
   `FFBA_ASSERT_IMP(a_result_from_done, clock, reset, $rose(rsp_valid_ff),
                    $past(state_ff) == ST_DONE)
endmodule

@@ test/tb_top.sv @@
// Self-checking testbench of the first-fit block allocator core.
`timescale 1ns / 1ps
// The testbench first walks a short table of hand-written requests. Rows whose outcome
// is obvious carry their expected status and grant. Then a sequence fills the allocated
// table and frees everything back, which drives the free table to full. Last come about
// 960 random requests, split into three phases of idling on the two channels.
// Every accepted transaction is run through a local copy of the allocator tables. The
// expected response is queued and compared with the next response that the core hands
// out. The third phase holds the response channel off for a long stretch, so the core
// fills up and stalls its request side.
module tb_top;
   import ffba_pkg::*;

   localparam int POOL      = 16777216;
   localparam int SLOTS     = 64;
   localparam int LIMIT     = 60000000;
   localparam int RAND_ITEMS = 960;

   typedef struct {
      status_type       st;
      logic [OFS_W-1:0] grant;
   } outcome_type;

   typedef struct {
      logic             op;
      logic [REQ_W-1:0] bytes;
      logic [OFS_W-1:0] start;
      bit               typed;
      status_type       st;
      logic [OFS_W-1:0] grant;
   } row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_opcode = OP_ALLOC;
   logic [REQ_W-1:0]    req_request_bytes = '0;
   logic [OFS_W-1:0]    req_block_start = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [OFS_W-1:0]    rsp_granted_start;

   first_fit_block_allocator_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_request_bytes(req_request_bytes), .req_block_start(req_block_start),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_granted_start(rsp_granted_start)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Local copy of the allocator tables. Blocks are half-open ranges [start, end).
   logic [ADDR_W-1:0] free_lo [SLOTS];
   logic [ADDR_W-1:0] free_hi [SLOTS];
   logic [ADDR_W-1:0] used_lo [SLOTS];
   logic [ADDR_W-1:0] used_hi [SLOTS];
   int                free_n;
   int                used_n;

   outcome_type pending_outcomes[$];
   int       errors = 0;
   int       cycles = 0;
   int       req_idle_pct = 35;
   int       rsp_idle_pct = 78;
   bit       hold_go = 1'b0;
   bit       hold_done = 1'b0;
   int       hold_left = 0;

   // First-fit search: split the block from its front, or take it whole on an exact fit.
   function automatic bit first_fit(input logic [REQ_W-1:0] want, output logic [OFS_W-1:0] g);
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] sz;
      for (int i = 0; i < free_n; i++) begin
         s  = free_lo[i];
         sz = free_hi[i] - s;
         if (sz >= want) begin
            used_lo[used_n] = s;
            used_hi[used_n] = s + want;
            used_n++;
            g = s[OFS_W-1:0];
            if (sz > want) begin
               free_lo[i] = s + want;
            end else begin
               for (int k = i; k + 1 < free_n; k++) begin
                  free_lo[k] = free_lo[k+1];
                  free_hi[k] = free_hi[k+1];
               end
               free_n--;
            end
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Insertion sort by start (ties by end), then merge touching neighbors.
   function automatic void coalesce_free();
      logic [ADDR_W-1:0] s, e;
      int j, w;
      if (free_n <= 1) return;
      for (int i = 1; i < free_n; i++) begin
         s = free_lo[i];
         e = free_hi[i];
         j = i;
         while (j > 0 && (free_lo[j-1] > s || (free_lo[j-1] == s && free_hi[j-1] > e))) begin
            free_lo[j] = free_lo[j-1];
            free_hi[j] = free_hi[j-1];
            j--;
         end
         free_lo[j] = s;
         free_hi[j] = e;
      end
      w = 0;
      for (int r = 1; r < free_n; r++) begin
         if (free_hi[w] == free_lo[r]) begin
            free_hi[w] = free_hi[r];
         end else begin
            w++;
            free_lo[w] = free_lo[r];
            free_hi[w] = free_hi[r];
         end
      end
      free_n = w + 1;
   endfunction

   function automatic outcome_type predict_allocation(input logic op,
                                                      input logic [REQ_W-1:0] want,
                                                      input logic [OFS_W-1:0] where);
      outcome_type o;
      int       hit;
      o.st    = STAT_OK;
      o.grant = '0;
      if (op == OP_ALLOC) begin
         if (used_n >= SLOTS) begin
            o.st = STAT_FULL;
         end else if (!first_fit(want, o.grant)) begin
            coalesce_free();
            if (!first_fit(want, o.grant)) begin
               o.st    = STAT_NOSPACE;
               o.grant = '0;
            end
         end
      end else begin
         hit = -1;
         for (int i = 0; i < used_n; i++) begin
            if (used_lo[i] == {1'b0, where}) begin
               hit = i;
               break;
            end
         end
         if (hit < 0) begin
            o.st = STAT_UNKNOWN;
         end else if (free_n >= SLOTS) begin
            o.st = STAT_FULL;
         end else begin
            free_lo[free_n] = used_lo[hit];
            free_hi[free_n] = used_hi[hit];
            free_n++;
            for (int k = hit; k + 1 < used_n; k++) begin
               used_lo[k] = used_lo[k+1];
               used_hi[k] = used_hi[k+1];
            end
            used_n--;
         end
      end
      return o;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   // Offers one transaction with a random lead-in gap and waits for its acceptance.
   // When typed is set, the hand-written outcome is expected instead of the predicted one;
   // the predictor still runs so that its tables stay in step.
   task automatic send_request(input logic op, input logic [REQ_W-1:0] want,
                               input logic [OFS_W-1:0] where, input bit typed = 1'b0,
                               input status_type st = STAT_OK,
                               input logic [OFS_W-1:0] g = '0);
      int       gap;
      outcome_type o;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_request_bytes <= want;
      req_block_start   <= where;
      do @(posedge clock); while (req_stall);
      o = predict_allocation(op, want, where);
      if (typed) begin
         o.st    = st;
         o.grant = g;
      end
      pending_outcomes.push_back(o);
   endtask

   task automatic random_request();
      logic [REQ_W-1:0] want;
      logic [OFS_W-1:0] where;
      int pick;
      want  = REQ_W'($urandom);
      where = OFS_W'($urandom);
      if ($urandom_range(99) < 55) begin
         pick = $urandom_range(99);
         if (pick < 70)      want = REQ_W'($urandom_range(0, 4096));
         else if (pick < 90) want = REQ_W'($urandom_range(0, 1 << 20));
         else if (pick < 98) want = REQ_W'($urandom_range(1 << 22, 1 << 24));
         send_request(OP_ALLOC, want, where);
      end else begin
         if (used_n > 0 && $urandom_range(99) < 85)
            where = used_lo[$urandom_range(0, used_n - 1)][OFS_W-1:0];
         send_request(OP_FREE, want, where);
      end
   endtask

   // Long hold-off of the response side, counted down in cycles.
   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 3000;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response side: check every accepted response, then decide the next stall.
   always @(posedge clock) begin
      outcome_type o;
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end else if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               flag_mismatch("response with nothing expected");
            end else begin
               o = pending_outcomes.pop_front();
               if (rsp_status !== o.st)
                  flag_mismatch($sformatf("status %0d, expected %0d", rsp_status, o.st));
               if (rsp_granted_start !== o.grant)
                  flag_mismatch($sformatf("granted_start %0h, expected %0h",
                                          rsp_granted_start, o.grant));
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   row_type rows[16];

   initial begin
      int fill;
      // Rows with a typed outcome can be read straight off the reset state.
      rows[0]  = '{OP_ALLOC, 25'd0,        24'd0,        1'b1, STAT_OK,      24'd0};
      rows[1]  = '{OP_ALLOC, 25'd16777216, 24'd0,        1'b1, STAT_OK,      24'd0};
      rows[2]  = '{OP_ALLOC, 25'd0,        24'd0,        1'b1, STAT_NOSPACE, 24'd0};
      rows[3]  = '{OP_FREE,  25'd0,        24'hFFFFFF,   1'b1, STAT_UNKNOWN, 24'd0};
      rows[4]  = '{OP_FREE,  25'd0,        24'd0,        1'b1, STAT_OK,      24'd0};
      rows[5]  = '{OP_FREE,  25'd0,        24'd0,        1'b1, STAT_OK,      24'd0};
      rows[6]  = '{OP_ALLOC, 25'd16777217, 24'd0,        1'b1, STAT_NOSPACE, 24'd0};
      rows[7]  = '{OP_ALLOC, 25'h1FFFFFF,  24'hFFFFFF,   1'b1, STAT_NOSPACE, 24'd0};
      rows[8]  = '{OP_ALLOC, 25'd100,      24'd0,        1'b1, STAT_OK,      24'd0};
      rows[9]  = '{OP_FREE,  25'h1FFFFFF,  24'd0,        1'b1, STAT_OK,      24'd0};
      rows[10] = '{OP_ALLOC, 25'd5,        24'd0,        1'b0, STAT_OK,      24'd0};
      rows[11] = '{OP_ALLOC, 25'd0,        24'd0,        1'b0, STAT_OK,      24'd0};
      rows[12] = '{OP_ALLOC, 25'd100,      24'd0,        1'b0, STAT_OK,      24'd0};
      rows[13] = '{OP_FREE,  25'd0,        24'd100,      1'b0, STAT_OK,      24'd0};
      rows[14] = '{OP_ALLOC, 25'd16777000, 24'd0,        1'b0, STAT_OK,      24'd0};
      rows[15] = '{OP_FREE,  25'd0,        24'd105,      1'b0, STAT_OK,      24'd0};

      for (int i = 0; i < SLOTS; i++) begin
         free_lo[i] = '0; free_hi[i] = '0; used_lo[i] = '0; used_hi[i] = '0;
      end
      free_hi[0] = POOL;
      free_n     = 1;
      used_n     = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_request(rows[i].op, rows[i].bytes, rows[i].start, rows[i].typed,
                      rows[i].st, rows[i].grant);

      // Fill the allocated table with tiny blocks, then release them all: the free
      // table runs full along the way, and later releases must report table full.
      fill = SLOTS - used_n + 1;
      repeat (fill) send_request(OP_ALLOC, 25'd1, OFS_W'($urandom));
      fill = used_n + 2;
      repeat (fill) send_request(OP_FREE, REQ_W'($urandom),
                                 used_n > 0 ? used_lo[0][OFS_W-1:0] : '0);
      send_request(OP_ALLOC, 25'd1, '0);
      send_request(OP_FREE, '0, used_lo[used_n-1][OFS_W-1:0]);

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            req_idle_pct = 78;
            rsp_idle_pct = 35;
         end else if (ph == 2) begin
            // No idling, but one long hold-off on the response side first.
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            hold_go      = 1'b1;
         end
         repeat (RAND_ITEMS / 3) random_request();
      end
      req_valid <= 1'b0;

      while (pending_outcomes.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
